/* design/pbp_pkg.sv */
package pbp_pkg;

    localparam int WEIGHT_W   = 8;
    localparam int SUM_OUT_W  = 14;
    localparam int THR_W      = 13;
    localparam int CNT_W      = 7;
    localparam int PC_W       = 32;

    localparam logic [THR_W-1:0]        THR_RESET = 13'd107;
    localparam logic [THR_W-1:0]        THR_MAX   = 13'd8191;
    localparam logic signed [CNT_W-1:0] CNT_HIGH  = 7'sd63;
    localparam logic signed [CNT_W-1:0] CNT_LOW   = -7'sd63;
    localparam logic signed [WEIGHT_W-1:0] W_MAX  = 8'sd127;
    localparam logic signed [WEIGHT_W-1:0] W_MIN  = -8'sd128;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef struct packed {
        logic                        low_confidence;
        logic signed [SUM_OUT_W-1:0] weighted_sum;
        logic                        predicted_taken;
    } result_t;

    // Step a weight by one toward agreement, saturating at both ends
    function automatic logic signed [WEIGHT_W-1:0] nudge(
        input logic signed [WEIGHT_W-1:0] w,
        input logic                       up
    );
        logic signed [WEIGHT_W-1:0] r;
        r = w;
        if (up) begin
            if (w != W_MAX) r = w + 8'sd1;
        end else begin
            if (w != W_MIN) r = w - 8'sd1;
        end
        return r;
    endfunction

endpackage

/* design/perceptron_branch_predictor_core.sv */
// Predict: the result passes stage 1 (memory read), stage 2 (partial sums) and the output
// queue; m_tvalid rises once the result has entered the queue.
// Throughput: one item per cycle while the output queue has room for predicts; an update directly
// after a predict waits while that predict is in stage 1, for the training flag.
// Every weight lane (one per used history position) has its own weight memory (one read and one write port).
// Reset: histories clear and the threshold returns to THR_RESET at once; a clearing pass then
// zeroes every row of the weight memories, with s_tready low.
module perceptron_branch_predictor_core #(
    parameter int SHORT_ROWS_LOG2 = 10,
    parameter int SHORT_POSITIONS = 5,
    parameter int LONG_POSITIONS  = 52,
    parameter int HISTORY_DEPTH   = 58
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pc[31:0], taken[32], predicted_dir[33], zero pad
    input  logic        s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // predicted_taken[0], weighted_sum[14:1], low_confidence[15]
);

    localparam int NL      = SHORT_POSITIONS + LONG_POSITIONS;
    localparam int AW      = SHORT_ROWS_LOG2;
    localparam int NG      = (NL + 7) / 8;
    localparam int GW      = pbp_pkg::WEIGHT_W + 4;
    localparam int SW      = GW + $clog2(NG) + 1;
    localparam int CW      = ((SW > pbp_pkg::THR_W + 1) ? SW : pbp_pkg::THR_W + 1) + 1;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    // Unpack input item
    logic                     in_op;
    logic [pbp_pkg::PC_W-1:0] in_pc;
    logic                     in_taken;
    logic                     in_pd;
    logic                     in_fire;

    assign in_op    = s_tuser;
    assign in_pc    = s_tdata[31:0];
    assign in_taken = s_tdata[32];
    assign in_pd    = s_tdata[33];

    // History and control state
    logic [pbp_pkg::PC_W-1:0] path_reg [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] dir_reg;
    logic [pbp_pkg::THR_W-1:0]        thr_reg;
    logic signed [pbp_pkg::CNT_W-1:0] cnt_reg;
    logic                             train_flag_reg;
    logic                             clearing_reg;
    logic [AW-1:0]                    clr_cnt_reg;

    // Stage 1 (memory data valid)
    logic          s1_valid_reg;
    logic          s1_op_reg;
    logic          s1_taken_reg;
    logic          s1_pd_reg;
    logic [AW-1:0] s1_addr_reg [NL];
    logic [NL-1:0] s1_bit_reg;
    logic          s1_pred;
    logic          s1_train;
    logic          s1_wr_en;

    // Forwarding of the last write-back
    logic                               fw_en_reg;
    logic [AW-1:0]                      fw_addr_reg [NL];
    logic signed [pbp_pkg::WEIGHT_W-1:0] fw_data_reg [NL];

    // Per-lane signals
    logic [AW-1:0]                       rd_addr  [NL];
    logic                                rd_bit   [NL];
    logic signed [pbp_pkg::WEIGHT_W-1:0] mem_q    [NL];
    logic signed [pbp_pkg::WEIGHT_W-1:0] w_cur    [NL];
    logic signed [pbp_pkg::WEIGHT_W-1:0] w_new    [NL];
    logic signed [pbp_pkg::WEIGHT_W:0]   contrib  [NL];

    // Stage 2 (partial sums)
    logic                 s2_valid_reg;
    logic signed [GW-1:0] grp_reg [NG];
    logic signed [GW-1:0] grp_next [NG];
    logic signed [SW-1:0] total;
    logic signed [CW-1:0] total_x;
    logic signed [CW-1:0] thr_x;
    pbp_pkg::result_t     res;

    // Output queue
    pbp_pkg::result_t q_reg [QDEPTH];
    logic [QAW-1:0]   q_wr_reg;
    logic [QAW-1:0]   q_rd_reg;
    logic [QAW:0]     q_cnt_reg;
    logic [QAW+1:0]   in_flight;
    logic             credit_ok;
    logic             q_push;
    logic             q_pop;

    assign s1_pred   = s1_valid_reg && (s1_op_reg == pbp_pkg::OP_PREDICT);
    assign in_flight = {1'b0, q_cnt_reg} + {{QAW+1{1'b0}}, s1_pred}
                     + {{QAW+1{1'b0}}, s2_valid_reg};
    assign credit_ok = in_flight < (QAW+2)'(QDEPTH);

    // Stall while clearing; hold a predict without credit, an update while a predict's flag is in flight
    always_comb begin
        if (clearing_reg) begin
            s_tready = 1'b0;
        end else if (in_op == pbp_pkg::OP_UPDATE) begin
            s_tready = !s1_pred;
        end else begin
            s_tready = credit_ok;
        end
    end

    assign in_fire = s_tvalid && s_tready;

    assign s1_train = (s1_taken_reg != s1_pd_reg) || train_flag_reg;
    assign s1_wr_en = s1_valid_reg && (s1_op_reg == pbp_pkg::OP_UPDATE) && s1_train;

    // Weight lanes: hash, memory, forwarding, nudge
    for (genvar L = 0; L < NL; L++) begin : g_lane
        localparam int N = (L < SHORT_POSITIONS) ? AW : AW - 1;

        logic [pbp_pkg::PC_W-1:0] h_cur;
        logic [pbp_pkg::PC_W-1:0] h_nxt;
        logic                     b_cur;
        logic                     b_nxt;
        logic [pbp_pkg::PC_W-1:0] h;
        logic [pbp_pkg::PC_W-1:0] mix;
        logic signed [pbp_pkg::WEIGHT_W-1:0] mem [2**N];
        logic signed [pbp_pkg::WEIGHT_W-1:0] q_reg_l;

        if (L < HISTORY_DEPTH) begin : g_cur
            assign h_cur = path_reg[L];
            assign b_cur = dir_reg[L];
        end else begin : g_cur0
            assign h_cur = '0;
            assign b_cur = 1'b0;
        end

        // After the update's shift, position L+1 holds today's bit L
        if (L + 1 < HISTORY_DEPTH) begin : g_nxt
            assign h_nxt = path_reg[L+1];
            assign b_nxt = dir_reg[L];
        end else begin : g_nxt0
            assign h_nxt = '0;
            assign b_nxt = 1'b0;
        end

        // Pick this position's past address and hash it with pc
        assign h         = (in_op == pbp_pkg::OP_UPDATE) ? h_nxt : h_cur;
        assign rd_bit[L] = (in_op == pbp_pkg::OP_UPDATE) ? b_nxt : b_cur;
        assign mix = (in_pc ^ (in_pc >> N)) ^ (h ^ (h >> N));
        assign rd_addr[L] = AW'(mix[N-1:0]);

        // Read every cycle; write back on training or during the clearing pass
        always_ff @(posedge aclk) begin
            q_reg_l <= mem[rd_addr[L][N-1:0]];
            if (clearing_reg) begin
                mem[clr_cnt_reg[N-1:0]] <= '0;
            end else if (s1_wr_en) begin
                mem[s1_addr_reg[L][N-1:0]] <= w_new[L];
            end
        end

        assign mem_q[L] = q_reg_l;

        // Forward a write-back that landed in the same cycle as this read
        assign w_cur[L] = (fw_en_reg && (fw_addr_reg[L] == s1_addr_reg[L]))
                        ? fw_data_reg[L] : mem_q[L];
        assign w_new[L] = pbp_pkg::nudge(w_cur[L], s1_taken_reg == s1_bit_reg[L]);
        assign contrib[L] = s1_bit_reg[L] ? {w_cur[L][pbp_pkg::WEIGHT_W-1], w_cur[L]}
                                          : -{w_cur[L][pbp_pkg::WEIGHT_W-1], w_cur[L]};
    end

    // Sum lanes in groups of eight
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < 8; k++) begin
                if (g * 8 + k < NL) begin
                    grp_next[g] = grp_next[g] + GW'(contrib[g*8+k]);
                end
            end
        end
    end

    // Final sum, sign and confidence
    always_comb begin
        total = '0;
        for (int g = 0; g < NG; g++) begin
            total = total + SW'(grp_reg[g]);
        end
        total_x = CW'(total);
        thr_x   = CW'(signed'({1'b0, thr_reg}));
        res.predicted_taken = !total[SW-1];
        res.weighted_sum    = pbp_pkg::SUM_OUT_W'(total);
        res.low_confidence  = (total_x > -thr_x) && (total_x < thr_x);
    end

    // Clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == {AW{1'b1}}) clearing_reg <= 1'b0;
        end
    end

    // Shift histories on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) path_reg[i] <= '0;
            dir_reg <= '0;
        end else if (in_fire) begin
            if (in_op == pbp_pkg::OP_PREDICT) begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--) path_reg[i] <= path_reg[i-1];
                path_reg[0] <= in_pc;
            end else begin
                dir_reg <= {dir_reg[HISTORY_DEPTH-2:0], in_taken};
            end
        end
    end

    // Advance stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fw_en_reg    <= 1'b0;
        end else begin
            s1_valid_reg <= in_fire;
            fw_en_reg    <= s1_wr_en;
        end
        s1_op_reg    <= in_op;
        s1_taken_reg <= in_taken;
        s1_pd_reg    <= in_pd;
        for (int i = 0; i < NL; i++) begin
            s1_addr_reg[i] <= rd_addr[i];
            s1_bit_reg[i]  <= rd_bit[i];
            fw_addr_reg[i] <= s1_addr_reg[i];
            fw_data_reg[i] <= w_new[i];
        end
    end

    // Adapt threshold on training
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= pbp_pkg::THR_RESET;
            cnt_reg <= '0;
        end else if (s1_wr_en) begin
            if (s1_taken_reg != s1_pd_reg) begin
                if (cnt_reg + 7'sd1 >= pbp_pkg::CNT_HIGH) begin
                    cnt_reg <= '0;
                    if (thr_reg != pbp_pkg::THR_MAX) thr_reg <= thr_reg + 13'd1;
                end else begin
                    cnt_reg <= cnt_reg + 7'sd1;
                end
            end else begin
                if (cnt_reg - 7'sd1 <= pbp_pkg::CNT_LOW) begin
                    cnt_reg <= '0;
                    if (thr_reg != '0) thr_reg <= thr_reg - 13'd1;
                end else begin
                    cnt_reg <= cnt_reg - 7'sd1;
                end
            end
        end
    end

    // Advance stage 2 and keep the training flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg   <= 1'b0;
            train_flag_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_pred;
            if (s2_valid_reg) train_flag_reg <= res.low_confidence;
        end
        for (int g = 0; g < NG; g++) grp_reg[g] <= grp_next[g];
    end

    // Output queue
    assign q_push   = s2_valid_reg;
    assign q_pop    = m_tvalid && m_tready;
    assign m_tvalid = q_cnt_reg != '0;
    assign m_tdata  = {q_reg[q_rd_reg].low_confidence,
                       q_reg[q_rd_reg].weighted_sum,
                       q_reg[q_rd_reg].predicted_taken};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            if (q_push) q_wr_reg <= q_wr_reg + QAW'(1);
            if (q_pop)  q_rd_reg <= q_rd_reg + QAW'(1);
            if (q_push && !q_pop) begin
                q_cnt_reg <= q_cnt_reg + (QAW+1)'(1);
            end else if (!q_push && q_pop) begin
                q_cnt_reg <= q_cnt_reg - (QAW+1)'(1);
            end
        end
        if (q_push) q_reg[q_wr_reg] <= res;
    end

    // Checks
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !in_fire)
        else $error("item accepted during clearing pass");

    a_update_after_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (s1_op_reg == pbp_pkg::OP_UPDATE)) |-> !s2_valid_reg)
        else $error("update trained before predict flag settled");

    a_no_write_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s1_valid_reg)
        else $error("item in flight during clearing pass");

endmodule
